// ===== src/basic_token_lexer_assert.svh =====
// ----------------------------------------------------------------------------
// basic token lexer assertion macros
// clocked property checks, compiled out when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef BASIC_TOKEN_LEXER_ASSERT_SVH
`define BASIC_TOKEN_LEXER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// checked on every edge outside reset
`define BLTX_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define BLTX_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BLTX_ASSERT(lbl, prop, msg)
`define BLTX_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== src/bltx_pkg.sv =====
// ----------------------------------------------------------------------------
// bltx_pkg
// shared types, character codes and classifier functions of the token lexer
// ----------------------------------------------------------------------------
`default_nettype none

package bltx_pkg;

	localparam int MAX_TOKEN_LEN_DEF = 32;
	localparam int RES_SLOTS = 4;

	// result events
	localparam logic [1:0] EV_CHAR       = 2'd0;
	localparam logic [1:0] EV_END        = 2'd1;
	localparam logic [1:0] EV_ERROR      = 2'd2;
	localparam logic [1:0] EV_SOURCE_END = 2'd3;

	// token kinds
	localparam logic [2:0] K_IDENT    = 3'd0;
	localparam logic [2:0] K_NUMBER   = 3'd1;
	localparam logic [2:0] K_VARIABLE = 3'd2;
	localparam logic [2:0] K_OPERATOR = 3'd3;
	localparam logic [2:0] K_LPAREN   = 3'd4;
	localparam logic [2:0] K_RPAREN   = 3'd5;
	localparam logic [2:0] K_STRING   = 3'd6;

	// character codes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_APOS   = 8'h27;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_A_UP   = 8'h41;
	localparam logic [7:0] CH_Z_UP   = 8'h5A;
	localparam logic [7:0] CH_A_LO   = 8'h61;
	localparam logic [7:0] CH_Z_LO   = 8'h7A;

	typedef enum logic [7:0] {
		M_IDLE     = 8'b0000_0001,
		M_IDENT    = 8'b0000_0010,
		M_NUMBER   = 8'b0000_0100,
		M_VARIABLE = 8'b0000_1000,
		M_STRING   = 8'b0001_0000,
		M_COMMENT  = 8'b0010_0000,
		M_COMPARE  = 8'b0100_0000,
		M_HALTED   = 8'b1000_0000
	} mode_t;

	typedef struct packed {
		logic [1:0] ev;
		logic [2:0] kind;
		logic [7:0] ch;
	} res_t;

	typedef res_t [RES_SLOTS-1:0] res_vec_t;

	// all results caused by one source word
	typedef struct packed {
		res_vec_t   slots;
		logic [2:0] cnt;
	} batch_t;

	// outcome of lexing a byte between tokens
	typedef struct packed {
		mode_t      mode;
		logic       pend_set;
		logic       len_one;
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} start_t;

	function automatic logic is_letter(input logic [7:0] b);
		return (b >= CH_A_UP && b <= CH_Z_UP) || (b >= CH_A_LO && b <= CH_Z_LO);
	endfunction

	function automatic logic is_decimal(input logic [7:0] b);
		return b >= CH_0 && b <= CH_9;
	endfunction

	function automatic logic is_single_op(input logic [7:0] b);
		return b == CH_PLUS || b == CH_MINUS || b == CH_STAR || b == CH_SLASH ||
			b == CH_PCT || b == CH_SEMI;
	endfunction

	function automatic logic is_token_mode(input mode_t m);
		return m == M_IDENT || m == M_NUMBER || m == M_VARIABLE || m == M_STRING;
	endfunction

	function automatic logic [2:0] mode_kind(input mode_t m);
		logic [2:0] k;
		k = K_IDENT;
		if (m == M_NUMBER) k = K_NUMBER;
		else if (m == M_VARIABLE) k = K_VARIABLE;
		else if (m == M_STRING) k = K_STRING;
		return k;
	endfunction

	function automatic logic token_takes(input mode_t m, input logic [7:0] b);
		logic t;
		if (m == M_IDENT || m == M_VARIABLE) t = is_letter(b);
		else if (m == M_NUMBER) t = is_decimal(b) || b == CH_DOT;
		else t = b != CH_QUOTE && b != CH_NUL;
		return t;
	endfunction

	function automatic res_t mk_res(input logic [1:0] ev, input logic [2:0] kind,
		input logic [7:0] ch);
		res_t r;
		r.ev   = ev;
		r.kind = kind;
		r.ch   = ch;
		return r;
	endfunction

	function automatic start_t start_byte(input logic [7:0] b);
		start_t s;
		s.mode     = M_IDLE;
		s.pend_set = 1'b0;
		s.len_one  = 1'b0;
		s.cnt      = 2'd0;
		s.r0       = '0;
		s.r1       = '0;
		if (b == CH_NUL) begin
			s.mode = M_HALTED;
		end else if (b == CH_SPACE || b == CH_TAB || b == CH_LF) begin
			s.mode = M_IDLE;
		end else if (is_letter(b)) begin
			s.mode    = M_IDENT;
			s.len_one = 1'b1;
			s.cnt     = 2'd1;
			s.r0      = mk_res(EV_CHAR, K_IDENT, b);
		end else if (is_decimal(b)) begin
			s.mode    = M_NUMBER;
			s.len_one = 1'b1;
			s.cnt     = 2'd1;
			s.r0      = mk_res(EV_CHAR, K_NUMBER, b);
		end else if (b == CH_DOLLAR) begin
			s.mode = M_VARIABLE;
		end else if (is_single_op(b) || b == CH_LPAREN || b == CH_RPAREN) begin
			s.cnt = 2'd2;
			if (b == CH_LPAREN) begin
				s.r0 = mk_res(EV_CHAR, K_LPAREN, b);
				s.r1 = mk_res(EV_END, K_LPAREN, CH_NUL);
			end else if (b == CH_RPAREN) begin
				s.r0 = mk_res(EV_CHAR, K_RPAREN, b);
				s.r1 = mk_res(EV_END, K_RPAREN, CH_NUL);
			end else begin
				s.r0 = mk_res(EV_CHAR, K_OPERATOR, b);
				s.r1 = mk_res(EV_END, K_OPERATOR, CH_NUL);
			end
		end else if (b == CH_QUOTE) begin
			s.mode = M_STRING;
		end else if (b == CH_APOS) begin
			s.mode = M_COMMENT;
		end else if (b == CH_LT || b == CH_GT) begin
			s.mode     = M_COMPARE;
			s.pend_set = 1'b1;
		end else begin
			s.cnt = 2'd1;
			s.r0  = mk_res(EV_ERROR, K_IDENT, b);
		end
		return s;
	endfunction

	function automatic res_vec_t put(input res_vec_t v, input logic [2:0] n, input res_t r);
		res_vec_t o;
		o = v;
		if (n < 3'(RES_SLOTS)) o[n[1:0]] = r;
		return o;
	endfunction

endpackage

`default_nettype wire

// ===== src/bltx_lex.sv =====
// ----------------------------------------------------------------------------
// bltx_lex
// lexer state and the single-pass step that turns one source word into results
// ----------------------------------------------------------------------------
`default_nettype none

module bltx_lex
	import bltx_pkg::*;
#(
	parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,
	input  wire logic [7:0] source_byte,
	input  wire logic       final_byte,
	output batch_t          batch
);

	localparam int LW = $clog2(MAX_TOKEN_LEN);
	localparam logic [LW-1:0] LIMIT = LW'(MAX_TOKEN_LEN - 1);

	mode_t         mode_q, mode_n;
	logic [LW-1:0] len_q, len_n;
	logic [7:0]    pend_q, pend_n;

	start_t     st;
	logic       do_start;
	res_vec_t   v;
	logic [2:0] n;
	logic [7:0] b;

	assign b  = source_byte;
	assign st = start_byte(b);

	always_comb begin
		mode_n   = mode_q;
		len_n    = len_q;
		pend_n   = pend_q;
		do_start = 1'b0;
		v        = '0;
		n        = 3'd0;
		unique case (mode_q)
			M_IDENT, M_NUMBER, M_VARIABLE, M_STRING: begin
				if (len_q < LIMIT && token_takes(mode_q, b)) begin
					v     = put(v, n, mk_res(EV_CHAR, mode_kind(mode_q), b));
					n     = n + 3'd1;
					len_n = len_q + LW'(1);
				end else begin
					v = put(v, n, mk_res(EV_END, mode_kind(mode_q), CH_NUL));
					n = n + 3'd1;
					// closing quote is consumed even when the string was cut
					if (mode_q == M_STRING && b == CH_QUOTE) begin
						mode_n = M_IDLE;
						len_n  = '0;
					end else begin
						do_start = 1'b1;
					end
				end
			end
			M_COMMENT: begin
				if (b == CH_LF) mode_n = M_IDLE;
				else if (b == CH_NUL) mode_n = M_HALTED;
			end
			M_COMPARE: begin
				if (b == CH_EQ || (pend_q == CH_LT && b == CH_GT)) begin
					v      = put(v, n, mk_res(EV_CHAR, K_OPERATOR, pend_q));
					v      = put(v, n + 3'd1, mk_res(EV_CHAR, K_OPERATOR, b));
					v      = put(v, n + 3'd2, mk_res(EV_END, K_OPERATOR, CH_NUL));
					n      = n + 3'd3;
					mode_n = M_IDLE;
				end else begin
					// lone compare is reported, then the byte is lexed afresh
					v        = put(v, n, mk_res(EV_ERROR, K_IDENT, pend_q));
					n        = n + 3'd1;
					do_start = 1'b1;
				end
			end
			M_HALTED: begin
				mode_n = M_HALTED;
			end
			M_IDLE: begin
				do_start = 1'b1;
			end
			default: begin
				mode_n = M_IDLE;
			end
		endcase

		if (do_start) begin
			mode_n = st.mode;
			len_n  = LW'(st.len_one);
			if (st.pend_set) pend_n = b;
			if (st.cnt != 2'd0) v = put(v, n, st.r0);
			if (st.cnt == 2'd2) v = put(v, n + 3'd1, st.r1);
			n = n + {1'b0, st.cnt};
		end

		if (final_byte) begin
			if (is_token_mode(mode_n)) begin
				v = put(v, n, mk_res(EV_END, mode_kind(mode_n), CH_NUL));
				n = n + 3'd1;
			end else if (mode_n == M_COMPARE) begin
				v = put(v, n, mk_res(EV_ERROR, K_IDENT, pend_n));
				n = n + 3'd1;
			end
			v      = put(v, n, mk_res(EV_SOURCE_END, K_IDENT, CH_NUL));
			n      = n + 3'd1;
			mode_n = M_IDLE;
			len_n  = '0;
			pend_n = CH_NUL;
		end

		batch.slots = v;
		batch.cnt   = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			len_q  <= '0;
			pend_q <= CH_NUL;
		end else if (fire) begin
			mode_q <= mode_n;
			len_q  <= len_n;
			pend_q <= pend_n;
		end
	end

`include "basic_token_lexer_assert.svh"

	`BLTX_ASSERT(a_final_resets, fire && final_byte |=> mode_q == M_IDLE && len_q == '0, "final word did not return lexer to idle")
	`BLTX_ASSERT(a_final_has_end, fire && final_byte |-> batch.cnt != 3'd0, "final word produced no source end")
	`BLTX_ASSERT(a_len_bound, fire |=> len_q <= LIMIT, "token length past limit")

endmodule

`default_nettype wire

// ===== src/bltx_outbuf.sv =====
// ----------------------------------------------------------------------------
// bltx_outbuf
// result register: holds one word's results and, while out_ready is high, hands them out one a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module bltx_outbuf
	import bltx_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire batch_t     batch,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      event_res,
	output logic [2:0]      kind,
	output logic [7:0]      character,
	output logic            run_last
);

	res_vec_t   slot_q;
	logic [2:0] cnt_q;
	logic [1:0] rd_q;
	logic       in_fire, out_fire;
	res_t       cur;

	// a new word may load when empty or once the last pending result leaves this cycle
	assign in_ready  = cnt_q == 3'd0 || (cnt_q == 3'd1 && out_ready);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = cnt_q != 3'd0;
	assign out_fire  = out_valid && out_ready;
	assign cur       = slot_q[rd_q];

	assign event_res = cur.ev;
	assign kind      = cur.kind;
	assign character = cur.ch;
	assign run_last  = cnt_q == 3'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			rd_q  <= 2'd0;
		end else if (in_fire) begin
			cnt_q <= batch.cnt;
			rd_q  <= 2'd0;
		end else if (out_fire) begin
			cnt_q <= cnt_q - 3'd1;
			rd_q  <= rd_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) slot_q <= batch.slots;
	end

`include "basic_token_lexer_assert.svh"

	`BLTX_ASSERT(a_load_shows, in_fire && batch.cnt != 3'd0 |=> out_valid && rd_q == 2'd0, "loaded results not presented")
	`BLTX_ASSERT(a_drain_empty, out_fire && run_last && !in_valid |=> !out_valid, "result shown after last one taken")
	`BLTX_ASSERT(a_cnt_bound, cnt_q <= 3'(RES_SLOTS), "result count beyond slots")

endmodule

`default_nettype wire

// ===== src/basic_token_lexer.sv =====
// ----------------------------------------------------------------------------
// basic_token_lexer
// streaming lexer for BASIC source text, one byte in, token results out
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) takes one source word: source_byte and
//   final_byte, the latter marking the last byte of the source text.
//   output channel (out_valid/out_ready) gives results one word at a time:
//   token characters, token ends carrying the kind, error bytes and the
//   source end; run_last flags the last result caused by an input word.
// timing: the results of a word are registered and appear in the cycle after it is accepted.
// throughput: a word yields up to four results; the result register drains
//   one result per cycle while out_ready is high, and the next input word
//   is taken in the cycle its last result leaves.
// reset: arst_n clears the lexer to idle and empties the result register.
// stall: while out_ready is low the current result holds, and in_ready
//   stays low once results are pending, so nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module basic_token_lexer
	import bltx_pkg::*;
#(
	parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] source_byte,
	input  wire logic       final_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      event_res,
	output logic [2:0]      kind,
	output logic [7:0]      character,
	output logic            run_last
);

	batch_t batch;
	logic   fire;

	assign fire = in_valid && in_ready;

	bltx_lex #(
		.MAX_TOKEN_LEN(MAX_TOKEN_LEN)
	) u_lex (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.source_byte (source_byte),
		.final_byte  (final_byte),
		.batch       (batch)
	);

	bltx_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.batch     (batch),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.event_res (event_res),
		.kind      (kind),
		.character (character),
		.run_last  (run_last)
	);

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: basic_token_lexer testbench
// feeds BASIC source text one byte per word, predicts the token words every
// byte causes and checks each output word, field by field, in order. a short
// directed run comes first, then random lexemes with random gaps on both sides
// ----------------------------------------------------------------------------
module tb;
	import bltx_pkg::*;

	localparam int TOKEN_CAP    = MAX_TOKEN_LEN_DEF - 1;
	localparam int RANDOM_ITEMS = 340;
	localparam int STALL_LIMIT  = 1000;
	localparam int CALM_LO      = 140;
	localparam int CALM_HI      = 210;
	localparam logic [2:0] NO_KIND = 3'd0;

	typedef struct packed {
		logic [1:0] ev;
		logic [2:0] kind;
		logic [7:0] ch;
		logic       last_word;
	} lex_result_t;

	localparam lex_result_t NO_WORD = '0;

	// one source word; typed rows carry their expected words written out
	typedef struct packed {
		logic [7:0]        b;
		logic              fin;
		logic              typed;
		logic [2:0]        n;
		lex_result_t [3:0] r;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] source_byte = 8'd0;
	logic       final_byte = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] event_res;
	logic [2:0] kind;
	logic [7:0] character;
	logic       run_last;

	stim_row_t   source_text[$];
	stim_row_t   src_row = '0;
	lex_result_t words_due[$];
	lex_result_t step_out[$];

	// lexer state as the predictor sees it
	mode_t      lx_mode = M_IDLE;
	logic [7:0] lx_pend = 8'd0;
	int         lx_len = 0;

	bit calm = 1'b0;
	int sink_hold = 0;
	int quiet_cycles = 0;
	int mismatches = 0;
	int bytes_taken = 0;
	int words_seen = 0;
	int cuts = 0;
	int src_ends = 0;
	int peak_words = 0;

	basic_token_lexer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.source_byte(source_byte),
		.final_byte (final_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.event_res  (event_res),
		.kind       (kind),
		.character  (character),
		.run_last   (run_last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic lex_result_t res(input logic [1:0] ev, input logic [2:0] k,
		input logic [7:0] c, input logic l);
		lex_result_t w;
		w.ev        = ev;
		w.kind      = k;
		w.ch        = c;
		w.last_word = l;
		return w;
	endfunction

	function automatic int pause_len(input bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// ---------------- predictor ----------------

	function automatic bit alpha(input logic [7:0] b);
		return (b >= CH_A_UP && b <= CH_Z_UP) || (b >= CH_A_LO && b <= CH_Z_LO);
	endfunction

	function automatic bit numeral(input logic [7:0] b);
		return b >= CH_0 && b <= CH_9;
	endfunction

	function automatic bit in_token(input mode_t m);
		return m == M_IDENT || m == M_NUMBER || m == M_VARIABLE || m == M_STRING;
	endfunction

	function automatic logic [2:0] kind_of(input mode_t m);
		case (m)
			M_NUMBER:   return K_NUMBER;
			M_VARIABLE: return K_VARIABLE;
			M_STRING:   return K_STRING;
			default:    return K_IDENT;
		endcase
	endfunction

	function automatic bit extends_token(input mode_t m, input logic [7:0] b);
		if (m == M_NUMBER) return numeral(b) || b == CH_DOT;
		if (m == M_STRING) return b != CH_QUOTE && b != CH_NUL;
		return alpha(b);
	endfunction

	task automatic note(input logic [1:0] ev, input logic [2:0] k, input logic [7:0] c);
		if (step_out.size() < RES_SLOTS) step_out.push_back(res(ev, k, c, 1'b0));
	endtask

	// byte met between tokens
	task automatic open_token(input logic [7:0] b);
		lx_mode = M_IDLE;
		lx_len  = 0;
		if (b == CH_NUL) begin
			lx_mode = M_HALTED;
		end else if (b == CH_SPACE || b == CH_TAB || b == CH_LF) begin
		end else if (alpha(b)) begin
			lx_mode = M_IDENT;
			lx_len  = 1;
			note(EV_CHAR, K_IDENT, b);
		end else if (numeral(b)) begin
			lx_mode = M_NUMBER;
			lx_len  = 1;
			note(EV_CHAR, K_NUMBER, b);
		end else if (b == CH_DOLLAR) begin
			lx_mode = M_VARIABLE;
		end else if (b == CH_PLUS || b == CH_MINUS || b == CH_STAR || b == CH_SLASH ||
			b == CH_PCT || b == CH_SEMI) begin
			note(EV_CHAR, K_OPERATOR, b);
			note(EV_END, K_OPERATOR, CH_NUL);
		end else if (b == CH_LPAREN) begin
			note(EV_CHAR, K_LPAREN, b);
			note(EV_END, K_LPAREN, CH_NUL);
		end else if (b == CH_RPAREN) begin
			note(EV_CHAR, K_RPAREN, b);
			note(EV_END, K_RPAREN, CH_NUL);
		end else if (b == CH_QUOTE) begin
			lx_mode = M_STRING;
		end else if (b == CH_APOS) begin
			lx_mode = M_COMMENT;
		end else if (b == CH_LT || b == CH_GT) begin
			lx_mode = M_COMPARE;
			lx_pend = b;
		end else begin
			note(EV_ERROR, NO_KIND, b);
		end
	endtask

	// token words caused by one source word, left in step_out
	task automatic scan_byte(input logic [7:0] b, input logic fin);
		logic [7:0] p;
		step_out.delete();
		if (in_token(lx_mode)) begin
			if (lx_len < TOKEN_CAP && extends_token(lx_mode, b)) begin
				note(EV_CHAR, kind_of(lx_mode), b);
				lx_len++;
			end else begin
				if (lx_len >= TOKEN_CAP && extends_token(lx_mode, b)) cuts++;
				note(EV_END, kind_of(lx_mode), CH_NUL);
				// a full string still swallows its closing quote
				if (lx_mode == M_STRING && b == CH_QUOTE) begin
					lx_mode = M_IDLE;
					lx_len  = 0;
				end else begin
					open_token(b);
				end
			end
		end else begin
			case (lx_mode)
				M_COMMENT: begin
					if (b == CH_LF) lx_mode = M_IDLE;
					else if (b == CH_NUL) lx_mode = M_HALTED;
				end
				M_COMPARE: begin
					p = lx_pend;
					lx_pend = 8'd0;
					if (b == CH_EQ || (p == CH_LT && b == CH_GT)) begin
						note(EV_CHAR, K_OPERATOR, p);
						note(EV_CHAR, K_OPERATOR, b);
						note(EV_END, K_OPERATOR, CH_NUL);
						lx_mode = M_IDLE;
					end else begin
						note(EV_ERROR, NO_KIND, p);
						open_token(b);
					end
				end
				M_HALTED: begin
				end
				default: open_token(b);
			endcase
		end
		if (fin) begin
			if (in_token(lx_mode)) note(EV_END, kind_of(lx_mode), CH_NUL);
			else if (lx_mode == M_COMPARE) note(EV_ERROR, NO_KIND, lx_pend);
			note(EV_SOURCE_END, NO_KIND, CH_NUL);
			src_ends++;
			lx_mode = M_IDLE;
			lx_pend = 8'd0;
			lx_len  = 0;
		end
		if (step_out.size() != 0) step_out[step_out.size() - 1].last_word = 1'b1;
		if (step_out.size() > peak_words) peak_words = step_out.size();
	endtask

	// ---------------- stimulus ----------------

	task automatic add(input logic [7:0] b, input logic fin);
		stim_row_t row;
		row     = '0;
		row.b   = b;
		row.fin = fin;
		source_text.push_back(row);
	endtask

	function automatic stim_row_t known(input logic [7:0] b, input logic fin,
		input logic [2:0] n, input lex_result_t r0, input lex_result_t r1,
		input lex_result_t r2, input lex_result_t r3);
		stim_row_t row;
		row       = '0;
		row.b     = b;
		row.fin   = fin;
		row.typed = 1'b1;
		row.n     = n;
		row.r[0]  = r0;
		row.r[1]  = r1;
		row.r[2]  = r2;
		row.r[3]  = r3;
		return row;
	endfunction

	function automatic logic [7:0] rand_letter();
		if ($urandom_range(0, 1) == 0) return CH_A_UP + 8'($urandom_range(0, 25));
		return CH_A_LO + 8'($urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] blank();
		case ($urandom_range(0, 2))
			0:       return CH_SPACE;
			1:       return CH_TAB;
			default: return CH_LF;
		endcase
	endfunction

	function automatic logic [7:0] punct();
		case ($urandom_range(0, 7))
			0:       return CH_PLUS;
			1:       return CH_MINUS;
			2:       return CH_STAR;
			3:       return CH_SLASH;
			4:       return CH_PCT;
			5:       return CH_SEMI;
			6:       return CH_LPAREN;
			default: return CH_RPAREN;
		endcase
	endfunction

	// one random lexeme, mostly well formed, some noise
	task automatic random_lexeme();
		int pick;
		int len;
		logic [7:0] c;
		pick = $urandom_range(0, 99);
		len  = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 6);
		if (pick < 18) begin
			repeat (len) add(rand_letter(), 1'b0);
		end else if (pick < 30) begin
			add(CH_0 + 8'($urandom_range(0, 9)), 1'b0);
			repeat (len - 1) begin
				if ($urandom_range(0, 4) == 0) add(CH_DOT, 1'b0);
				else add(CH_0 + 8'($urandom_range(0, 9)), 1'b0);
			end
		end else if (pick < 38) begin
			add(CH_DOLLAR, 1'b0);
			if ($urandom_range(0, 3) != 0) repeat (len) add(rand_letter(), 1'b0);
		end else if (pick < 48) begin
			add(CH_QUOTE, 1'b0);
			repeat (len) begin
				c = 8'($urandom_range(1, 255));
				if (c == CH_QUOTE) c = CH_SPACE;
				add(c, 1'b0);
			end
			if ($urandom_range(0, 9) != 0) add(CH_QUOTE, 1'b0);
		end else if (pick < 53) begin
			add(CH_APOS, 1'b0);
			repeat ($urandom_range(0, 5)) begin
				c = 8'($urandom_range(1, 255));
				if (c == CH_LF) c = CH_SPACE;
				add(c, 1'b0);
			end
			add(CH_LF, 1'b0);
		end else if (pick < 63) begin
			add(($urandom_range(0, 1) == 0) ? CH_LT : CH_GT, 1'b0);
			case ($urandom_range(0, 3))
				0:       add(CH_EQ, 1'b0);
				1:       add(CH_GT, 1'b0);
				2:       add(CH_LT, 1'b0);
				default: add(8'($urandom_range(1, 255)), 1'b0);
			endcase
		end else if (pick < 73) begin
			add(punct(), 1'b0);
		end else if (pick < 80) begin
			add(blank(), 1'b0);
		end else if (pick < 92) begin
			add(8'($urandom_range(0, 255)), 1'b0);
		end else if (pick < 96) begin
			// halt, a few ignored bytes, then end of source
			add(CH_NUL, 1'b0);
			repeat ($urandom_range(0, 3)) add(8'($urandom_range(0, 255)), 1'b0);
			add(8'($urandom_range(0, 255)), 1'b1);
		end else begin
			add(8'($urandom_range(0, 255)), 1'b1);
		end
		if ($urandom_range(0, 1) == 0) add(blank(), 1'b0);
	endtask

	task automatic build_source();
		int directed;
		source_text.push_back(known(CH_LPAREN, 1'b0, 3'd2,
			res(EV_CHAR, K_LPAREN, CH_LPAREN, 1'b0), res(EV_END, K_LPAREN, CH_NUL, 1'b1),
			NO_WORD, NO_WORD));
		source_text.push_back(known(CH_RPAREN, 1'b0, 3'd2,
			res(EV_CHAR, K_RPAREN, CH_RPAREN, 1'b0), res(EV_END, K_RPAREN, CH_NUL, 1'b1),
			NO_WORD, NO_WORD));
		source_text.push_back(known(CH_PLUS, 1'b0, 3'd2,
			res(EV_CHAR, K_OPERATOR, CH_PLUS, 1'b0), res(EV_END, K_OPERATOR, CH_NUL, 1'b1),
			NO_WORD, NO_WORD));
		add(CH_MINUS, 1'b0);
		add(CH_STAR, 1'b0);
		add(CH_SLASH, 1'b0);
		add(CH_PCT, 1'b0);
		add(CH_SEMI, 1'b0);
		add(CH_A_UP, 1'b0);
		add(CH_9, 1'b0);
		add(CH_DOLLAR, 1'b0);
		add("q", 1'b0);
		add(CH_LT, 1'b0);
		add(CH_GT, 1'b0);
		add(CH_GT, 1'b0);
		add(CH_EQ, 1'b0);
		// lone compare followed by an empty string
		add(CH_LT, 1'b0);
		add(CH_QUOTE, 1'b0);
		add(CH_QUOTE, 1'b0);
		add(CH_APOS, 1'b0);
		add(CH_LF, 1'b0);
		source_text.push_back(known(CH_EQ, 1'b0, 3'd1,
			res(EV_ERROR, NO_KIND, CH_EQ, 1'b1), NO_WORD, NO_WORD, NO_WORD));
		source_text.push_back(known(8'hFF, 1'b0, 3'd1,
			res(EV_ERROR, NO_KIND, 8'hFF, 1'b1), NO_WORD, NO_WORD, NO_WORD));
		// nul halts, the final byte is then ignored apart from the source end
		add("a", 1'b0);
		add(CH_NUL, 1'b0);
		source_text.push_back(known("x", 1'b1, 3'd1,
			res(EV_SOURCE_END, NO_KIND, CH_NUL, 1'b1), NO_WORD, NO_WORD, NO_WORD));
		add(CH_LT, 1'b0);
		source_text.push_back(known(CH_LPAREN, 1'b1, 3'd4,
			res(EV_ERROR, NO_KIND, CH_LT, 1'b0), res(EV_CHAR, K_LPAREN, CH_LPAREN, 1'b0),
			res(EV_END, K_LPAREN, CH_NUL, 1'b0), res(EV_SOURCE_END, NO_KIND, CH_NUL, 1'b1)));
		directed = source_text.size();
		while (source_text.size() - directed < RANDOM_ITEMS) random_lexeme();
	endtask

	// ---------------- output side ----------------

	always @(posedge clk) begin
		if (sink_hold != 0) begin
			out_ready <= 1'b0;
			sink_hold <= sink_hold - 1;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 3) == 0) sink_hold <= pause_len(calm);
		end
	end

	always @(posedge clk) begin : monitor
		lex_result_t got;
		lex_result_t want;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == STALL_LIMIT) begin
				$display("no handshake for %0d cycles, %0d words still due",
					STALL_LIMIT, words_due.size());
				$display("FAILED: results differ");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (in_valid && in_ready) begin
				bytes_taken++;
				scan_byte(source_byte, final_byte);
				if (src_row.typed) begin
					for (int k = 0; k < src_row.n; k++) words_due.push_back(src_row.r[k]);
				end else begin
					foreach (step_out[k]) words_due.push_back(step_out[k]);
				end
			end
			if (out_valid && out_ready) begin
				got = res(event_res, kind, character, run_last);
				words_seen++;
				if (words_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected word: ev=%0d kind=%0d ch=%02h last=%0d",
							got.ev, got.kind, got.ch, got.last_word);
				end else begin
					want = words_due.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"word %0d: expected ev=%0d kind=%0d ch=%02h last=%0d,",
								" got ev=%0d kind=%0d ch=%02h last=%0d"}, words_seen,
								want.ev, want.kind, want.ch, want.last_word,
								got.ev, got.kind, got.ch, got.last_word);
					end
				end
			end
		end
	end

	// ---------------- input side and run control ----------------

	initial begin
		int gap;
		bit quiet;
		build_source();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < source_text.size(); i++) begin
			quiet = (i >= CALM_LO && i < CALM_HI);
			calm <= quiet;
			gap = pause_len(quiet);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid    <= 1'b1;
			src_row     <= source_text[i];
			source_byte <= source_text[i].b;
			final_byte  <= source_text[i].fin;
			@(posedge clk);
			while (!in_ready) @(posedge clk);
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("lexed %0d source bytes into %0d words over %0d sources",
			bytes_taken, words_seen, src_ends);
		$display("tokens cut at the length cap: %0d, most words from one byte: %0d",
			cuts, peak_words);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatching words", mismatches);
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/bltx_pkg.sv
src/bltx_lex.sv
src/bltx_outbuf.sv
src/basic_token_lexer.sv
bench/tb.sv
